>>> design/dtr_pkg.sv
package dtr_pkg;

   // table size unless overridden at the top level
   localparam int TABLE_DEPTH_DEFAULT = 256;

   // entries searched after reset
   localparam logic [8:0] ENTRIES_RESET = 9'd256;

   // pipeline lengths of the arithmetic units
   localparam int ISQ_LAT = 16;
   localparam int DIV_LAT = 21;

   // command codes
   localparam logic CMD_LOAD    = 1'b0;
   localparam logic CMD_CONVERT = 1'b1;

   // error codes
   localparam logic [1:0] ERR_OK   = 2'd0;
   localparam logic [1:0] ERR_FLAT = 2'd1;
   localparam logic [1:0] ERR_FEW  = 2'd2;

   // signed Q12.24 limits
   localparam logic signed [35:0] RED_MAX = 36'sh7_FFFF_FFFF;
   localparam logic signed [35:0] RED_MIN = 36'sh8_0000_0000;

   typedef struct packed {
      logic               cmd;
      logic [7:0]         entry_index;
      logic [31:0]        entry_distance;
      logic [31:0]        entry_redshift;
      logic signed [31:0] x_position;
      logic signed [31:0] y_position;
      logic signed [31:0] z_position;
      logic signed [35:0] acc_in;
   } req_payload_type;

   typedef struct packed {
      logic signed [35:0] redshift;
      logic signed [35:0] acc_out;
      logic [31:0]        distance;
      logic [1:0]         error_code;
   } rsp_payload_type;

endpackage

>>> design/dtr_stream_if.sv
interface dtr_stream_if #(parameter type payload_type = logic);

   logic        valid;
   logic        ready;
   payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);

endinterface

>>> design/dtr_isqrt.sv
// Floor square root of a 64-bit value, two result bits per stage.
module dtr_isqrt (
   input  logic        clock,
   input  logic        enable,
   input  logic [63:0] radicand,
   output logic [31:0] root
);

   localparam int STAGES = dtr_pkg::ISQ_LAT;

   typedef struct packed {
      logic [32:0] rem;
      logic [31:0] root;
   } isq_type;

   isq_type     st_ff   [STAGES];
   logic [63:0] rest_ff [STAGES];

   // one digit: bring down a bit pair, try root*4+1
   function automatic isq_type isq_step(isq_type cur, logic [1:0] pair);
      isq_type     nxt;
      logic [34:0] part;
      logic [34:0] trial;
      part  = {cur.rem, pair};
      trial = {1'b0, cur.root, 2'b01};
      if (part >= trial) begin
         nxt.rem  = 33'(part - trial);
         nxt.root = {cur.root[30:0], 1'b1};
      end else begin
         nxt.rem  = part[32:0];
         nxt.root = {cur.root[30:0], 1'b0};
      end
      return nxt;
   endfunction

   for (genvar j = 0; j < STAGES; j++) begin : g_stage
      isq_type     src;
      logic [63:0] bits;
      isq_type     st_in;

      if (j == 0) begin : g_first
         assign src  = '0;
         assign bits = radicand;
      end else begin : g_next
         assign src  = st_ff[j-1];
         assign bits = rest_ff[j-1];
      end

      assign st_in = isq_step(isq_step(src, bits[63:62]), bits[61:60]);

      always_ff @(posedge clock) begin
         if (enable) begin
            st_ff[j]   <= st_in;
            rest_ff[j] <= {bits[59:0], 4'b0};
         end
      end
   end

   assign root = st_ff[STAGES-1].root;

endmodule

>>> design/dtr_divider.sv
// Truncating 64 / 32 divide, quotient capped at 2^40, two bits per stage.
module dtr_divider (
   input  logic        clock,
   input  logic        enable,
   input  logic [63:0] dividend,
   input  logic [31:0] divisor,
   output logic [40:0] quotient
);

   localparam int STAGES = dtr_pkg::DIV_LAT;

   logic [31:0] rem_ff [STAGES];
   logic [39:0] low_ff [STAGES];
   logic [39:0] quo_ff [STAGES];
   logic [31:0] dvs_ff [STAGES];
   logic        cap_ff [STAGES];

   typedef struct packed {
      logic [31:0] rem;
      logic [39:0] low;
      logic [39:0] quo;
   } div_type;

   // one restoring step
   function automatic div_type div_step(div_type cur, logic [31:0] dvs);
      div_type     nxt;
      logic [32:0] part;
      part = {cur.rem, cur.low[39]};
      nxt.low = {cur.low[38:0], 1'b0};
      if (part >= {1'b0, dvs}) begin
         nxt.rem = 32'(part - {1'b0, dvs});
         nxt.quo = {cur.quo[38:0], 1'b1};
      end else begin
         nxt.rem = part[31:0];
         nxt.quo = {cur.quo[38:0], 1'b0};
      end
      return nxt;
   endfunction

   // top 24 bits alone decide the cap; below it they start the remainder
   always_ff @(posedge clock) begin
      if (enable) begin
         rem_ff[0] <= {8'b0, dividend[63:40]};
         low_ff[0] <= dividend[39:0];
         quo_ff[0] <= '0;
         dvs_ff[0] <= divisor;
         cap_ff[0] <= {8'b0, dividend[63:40]} >= divisor;
      end
   end

   for (genvar j = 1; j < STAGES; j++) begin : g_stage
      div_type cur;
      div_type nxt_in;

      assign cur    = '{rem: rem_ff[j-1], low: low_ff[j-1], quo: quo_ff[j-1]};
      assign nxt_in = div_step(div_step(cur, dvs_ff[j-1]), dvs_ff[j-1]);

      always_ff @(posedge clock) begin
         if (enable) begin
            rem_ff[j] <= nxt_in.rem;
            low_ff[j] <= nxt_in.low;
            quo_ff[j] <= nxt_in.quo;
            dvs_ff[j] <= dvs_ff[j-1];
            cap_ff[j] <= cap_ff[j-1];
         end
      end
   end

   assign quotient = cap_ff[STAGES-1] ? {1'b1, 40'b0} : {1'b0, quo_ff[STAGES-1]};

endmodule

>>> design/distance_to_redshift_interpolator.sv
// Pipeline from request beat to response beat: 16 stages of square root, two per
// search step, 21 of divide.
// Throughput: one beat per cycle; a stalled response holds the whole pipeline.
// Reset clears pipeline valid bits and sets entries_ff to 256; table contents are
// undefined until loaded.
module distance_to_redshift_interpolator #(
   parameter int TABLE_DEPTH = dtr_pkg::TABLE_DEPTH_DEFAULT
) (
   input  logic       clock,
   input  logic       reset,
   dtr_stream_if.sink   req_chan,
   dtr_stream_if.source rsp_chan,
   input  logic       csr_write_enable,
   input  logic [8:0] csr_write_data
);

   localparam int AW    = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
   localparam int NW    = $clog2(TABLE_DEPTH + 1);
   localparam int STEPS = AW;
   localparam int ISQ_LAT = dtr_pkg::ISQ_LAT;
   localparam int DIV_LAT = dtr_pkg::DIV_LAT;

   typedef struct packed {
      logic               valid;
      logic               cmd;
      logic [AW-1:0]      idx;
      logic [31:0]        edist;
      logic [31:0]        ered;
      logic signed [35:0] acc;
   } item_type;

   typedef struct packed {
      logic               valid;
      logic               cmd;
      logic [AW-1:0]      idx;
      logic [31:0]        edist;
      logic [31:0]        ered;
      logic signed [35:0] acc;
      logic [31:0]        radius;
      logic               few;
      logic [AW-1:0]      lo;
      logic [AW-1:0]      hi;
   } srch_type;

   typedef struct packed {
      logic               live;
      logic signed [35:0] acc;
      logic [31:0]        radius;
      logic               few;
      logic               flat;
      logic               neg;
      logic [31:0]        z1;
   } intp_type;

   logic adv;
   logic [8:0] entries_ff;

   // pipeline advances unless the response register is full and stalled
   assign adv           = !rsp_chan.valid || rsp_chan.ready;
   assign req_chan.ready = adv;

   always_ff @(posedge clock) begin
      if (reset) begin
         entries_ff <= dtr_pkg::ENTRIES_RESET;
      end else if (csr_write_enable) begin
         entries_ff <= csr_write_data;
      end
   end

   // load index wraps modulo the depth
   logic [AW-1:0] wrap_lut [256];
   for (genvar i = 0; i < 256; i++) begin : g_wrap
      assign wrap_lut[i] = AW'(i % TABLE_DEPTH);
   end

   // ---------------- input, squares, sum ----------------
   item_type           s0_ff, s1_ff, s2_ff;
   item_type           s0_in;
   logic signed [31:0] x_ff, y_ff, z_ff;
   logic [63:0]        sqx_ff, sqy_ff, sqz_ff, sum_ff;
   logic [31:0]        mx, my, mz;

   always_comb begin
      s0_in.valid = req_chan.valid;
      s0_in.cmd   = req_chan.payload.cmd;
      s0_in.idx   = wrap_lut[req_chan.payload.entry_index];
      s0_in.edist = req_chan.payload.entry_distance;
      s0_in.ered  = req_chan.payload.entry_redshift;
      s0_in.acc   = req_chan.payload.acc_in;
   end

   assign mx = x_ff[31] ? 32'(~x_ff + 32'd1) : x_ff;
   assign my = y_ff[31] ? 32'(~y_ff + 32'd1) : y_ff;
   assign mz = z_ff[31] ? 32'(~z_ff + 32'd1) : z_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s0_ff.valid <= 1'b0;
         s1_ff.valid <= 1'b0;
         s2_ff.valid <= 1'b0;
      end else if (adv) begin
         s0_ff <= s0_in;
         s1_ff <= s0_ff;
         s2_ff <= s1_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         x_ff   <= req_chan.payload.x_position;
         y_ff   <= req_chan.payload.y_position;
         z_ff   <= req_chan.payload.z_position;
         sqx_ff <= 64'(mx) * 64'(mx);
         sqy_ff <= 64'(my) * 64'(my);
         sqz_ff <= 64'(mz) * 64'(mz);
         sum_ff <= sqx_ff + sqy_ff + sqz_ff;
      end
   end

   // ---------------- square root ----------------
   item_type    isq_side_ff [ISQ_LAT];
   logic [31:0] root;

   dtr_isqrt u_isqrt (
      .clock    (clock),
      .enable   (adv),
      .radicand (sum_ff),
      .root     (root)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < ISQ_LAT; i++) isq_side_ff[i].valid <= 1'b0;
      end else if (adv) begin
         isq_side_ff[0] <= s2_ff;
         for (int i = 1; i < ISQ_LAT; i++) isq_side_ff[i] <= isq_side_ff[i-1];
      end
   end

   // ---------------- search setup ----------------
   srch_type      srch_init_ff, srch_init_in;
   logic [NW-1:0] n_use;
   item_type      isq_out;

   assign isq_out = isq_side_ff[ISQ_LAT-1];

   always_comb begin
      if (int'(entries_ff) > TABLE_DEPTH) n_use = NW'(TABLE_DEPTH);
      else n_use = NW'(entries_ff);
      srch_init_in.valid  = isq_out.valid;
      srch_init_in.cmd    = isq_out.cmd;
      srch_init_in.idx    = isq_out.idx;
      srch_init_in.edist  = isq_out.edist;
      srch_init_in.ered   = isq_out.ered;
      srch_init_in.acc    = isq_out.acc;
      srch_init_in.radius = root;
      srch_init_in.few    = n_use < NW'(2);
      srch_init_in.lo     = '0;
      srch_init_in.hi     = AW'(n_use - NW'(1));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         srch_init_ff.valid <= 1'b0;
      end else if (adv) begin
         srch_init_ff <= srch_init_in;
      end
   end

   // ---------------- binary search: read stage, compare stage ----------------
   srch_type      srch_a_ff [STEPS];
   srch_type      srch_b_ff [STEPS];
   logic [AW-1:0] mid_a_ff  [STEPS];
   logic          act_a_ff  [STEPS];
   logic [31:0]   rd_a_ff   [STEPS];

   for (genvar k = 0; k < STEPS; k++) begin : g_step
      srch_type      src;
      srch_type      nxt_in;
      logic [AW:0]   span;
      logic [AW-1:0] mid_in;
      logic          act_in;
      logic [31:0]   dmem [TABLE_DEPTH];

      if (k == 0) begin : g_first
         assign src = srch_init_ff;
      end else begin : g_next
         assign src = srch_b_ff[k-1];
      end

      assign span   = {1'b0, src.lo} + {1'b0, src.hi};
      assign mid_in = span[AW:1];
      assign act_in = ({1'b0, src.lo} + (AW+1)'(1)) < {1'b0, src.hi};

      // private copy of the distance table, loaded as the load beat passes
      always_ff @(posedge clock) begin
         if (adv) begin
            if (src.valid && src.cmd == dtr_pkg::CMD_LOAD) dmem[src.idx] <= src.edist;
            rd_a_ff[k]  <= dmem[mid_in];
            mid_a_ff[k] <= mid_in;
            act_a_ff[k] <= act_in;
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            srch_a_ff[k].valid <= 1'b0;
         end else if (adv) begin
            srch_a_ff[k] <= src;
         end
      end

      // strict less-than moves the low bound
      always_comb begin
         nxt_in = srch_a_ff[k];
         if (act_a_ff[k]) begin
            if (rd_a_ff[k] < srch_a_ff[k].radius) nxt_in.lo = mid_a_ff[k];
            else nxt_in.hi = mid_a_ff[k];
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            srch_b_ff[k].valid <= 1'b0;
         end else if (adv) begin
            srch_b_ff[k] <= nxt_in;
         end
      end
   end

   // ---------------- bracketing pair fetch ----------------
   srch_type      fsrc;
   logic [AW-1:0] lo_addr;
   logic [31:0]   fdmem [TABLE_DEPTH];
   logic [31:0]   fzmem [TABLE_DEPTH];
   logic [31:0]   d1_ff, d2_ff, z1_ff, z2_ff;
   intp_type      f_ff, f_in;

   assign fsrc    = srch_b_ff[STEPS-1];
   assign lo_addr = fsrc.hi - AW'(1);

   always_ff @(posedge clock) begin
      if (adv) begin
         if (fsrc.valid && fsrc.cmd == dtr_pkg::CMD_LOAD) begin
            fdmem[fsrc.idx] <= fsrc.edist;
            fzmem[fsrc.idx] <= fsrc.ered;
         end
         d1_ff <= fdmem[lo_addr];
         d2_ff <= fdmem[fsrc.hi];
         z1_ff <= fzmem[lo_addr];
         z2_ff <= fzmem[fsrc.hi];
      end
   end

   always_comb begin
      f_in        = '0;
      f_in.live   = fsrc.valid && fsrc.cmd == dtr_pkg::CMD_CONVERT;
      f_in.acc    = fsrc.acc;
      f_in.radius = fsrc.radius;
      f_in.few    = fsrc.few;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         f_ff.live <= 1'b0;
      end else if (adv) begin
         f_ff <= f_in;
      end
   end

   // ---------------- differences and signs ----------------
   logic [32:0] dx, dy, dd;
   intp_type    g_ff, g_in;
   logic [31:0] mdx_ff, mdy_ff, mdd_ff;

   function automatic logic [31:0] mag33(logic [32:0] v);
      logic [32:0] neg_v;
      neg_v = ~v + 33'd1;
      return v[32] ? neg_v[31:0] : v[31:0];
   endfunction

   assign dx = {1'b0, d2_ff} - {1'b0, d1_ff};
   assign dy = {1'b0, z2_ff} - {1'b0, z1_ff};
   assign dd = {1'b0, f_ff.radius} - {1'b0, d1_ff};

   always_comb begin
      g_in      = f_ff;
      g_in.flat = dx == '0;
      g_in.neg  = dx[32] ^ dy[32] ^ dd[32];
      g_in.z1   = z1_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         g_ff.live <= 1'b0;
      end else if (adv) begin
         g_ff <= g_in;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         mdx_ff <= mag33(dx);
         mdy_ff <= mag33(dy);
         mdd_ff <= mag33(dd);
      end
   end

   // ---------------- product ----------------
   intp_type    h_ff;
   logic [63:0] prod_ff;
   logic [31:0] hdx_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         h_ff.live <= 1'b0;
      end else if (adv) begin
         h_ff <= g_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         prod_ff <= 64'(mdy_ff) * 64'(mdd_ff);
         hdx_ff  <= mdx_ff;
      end
   end

   // ---------------- divide ----------------
   intp_type    div_side_ff [DIV_LAT];
   logic [40:0] quotient;

   dtr_divider u_divider (
      .clock    (clock),
      .enable   (adv),
      .dividend (prod_ff),
      .divisor  (hdx_ff),
      .quotient (quotient)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < DIV_LAT; i++) div_side_ff[i].live <= 1'b0;
      end else if (adv) begin
         div_side_ff[0] <= h_ff;
         for (int i = 1; i < DIV_LAT; i++) div_side_ff[i] <= div_side_ff[i-1];
      end
   end

   // ---------------- redshift ----------------
   function automatic logic signed [35:0] sat36(logic signed [42:0] v);
      if (v > 43'(dtr_pkg::RED_MAX)) return dtr_pkg::RED_MAX;
      if (v < 43'(dtr_pkg::RED_MIN)) return dtr_pkg::RED_MIN;
      return v[35:0];
   endfunction

   intp_type           dv;
   logic signed [42:0] zsum;
   logic               r_live_ff;
   logic signed [35:0] r_acc_ff, r_red_ff, r_red_in;
   logic [31:0]        r_dist_ff;
   logic [1:0]         r_err_ff, r_err_in;

   assign dv   = div_side_ff[DIV_LAT-1];
   assign zsum = dv.neg ? $signed({11'b0, dv.z1}) - $signed({2'b0, quotient})
                        : $signed({11'b0, dv.z1}) + $signed({2'b0, quotient});

   always_comb begin
      if (dv.few) begin
         r_err_in = dtr_pkg::ERR_FEW;
         r_red_in = '0;
      end else if (dv.flat) begin
         r_err_in = dtr_pkg::ERR_FLAT;
         r_red_in = '0;
      end else begin
         r_err_in = dtr_pkg::ERR_OK;
         r_red_in = sat36(zsum);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         r_live_ff <= 1'b0;
      end else if (adv) begin
         r_live_ff <= dv.live;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         r_acc_ff  <= dv.acc;
         r_red_ff  <= r_red_in;
         r_dist_ff <= dv.radius;
         r_err_ff  <= r_err_in;
      end
   end

   // ---------------- accumulate and output register ----------------
   logic                     rsp_valid_ff;
   dtr_pkg::rsp_payload_type rsp_ff, rsp_in;

   always_comb begin
      rsp_in.redshift   = r_red_ff;
      rsp_in.acc_out    = sat36(43'(r_acc_ff) + 43'(r_red_ff));
      rsp_in.distance   = r_dist_ff;
      rsp_in.error_code = r_err_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (adv) begin
         rsp_valid_ff <= r_live_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_chan.valid   = rsp_valid_ff;
   assign rsp_chan.payload = rsp_ff;

endmodule
